@@ rtl/assert_macros.svh @@
// Assertion macros used by the controller RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wrgc_pkg.sv @@
// Types and constants for the winch remote gesture controller.
// No dependencies; used by every module in rtl.
package wrgc_pkg;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DOUBLE_PRESS_WINDOW = 2'd0,
    REG_LONG_PRESS          = 2'd1,
    REG_AUTO_CTRL_ATTACHED  = 2'd2,
    REG_AUTO_OUT_ATTACHED   = 2'd3
  } reg_idx_t;

  localparam logic [15:0] RESET_DOUBLE_PRESS_MS = 16'd800;
  localparam logic [15:0] RESET_LONG_PRESS_MS   = 16'd2000;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [15:0] double_press_window_ms;
    logic [15:0] long_press_ms;
    logic        auto_controller_attached;
    logic        auto_output_attached;
  } cfg_t;

  typedef struct packed {
    logic        button_up;
    logic        button_down;
    logic        button_third;
    logic        button_fourth;
    logic [31:0] time_ms;
    logic        stop_flag_in;
    logic        auto_enabled_in;
  } sample_t;

  typedef struct packed {
    cmd_t winch_command;
    logic stop_flag_out;
    logic stop_flag_write;
    logic auto_disable;
    logic auto_output_zero;
    logic handled;
  } result_t;

endpackage

@@ rtl/wrgc_cfg.sv @@
// Configuration register file of the winch remote gesture controller.
// Depends on wrgc_pkg.
module wrgc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  wrgc_pkg::reg_idx_t                cfg_index,
  input  logic [wrgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wrgc_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_press_window_ms   <= wrgc_pkg::RESET_DOUBLE_PRESS_MS;
      cfg.long_press_ms            <= wrgc_pkg::RESET_LONG_PRESS_MS;
      cfg.auto_controller_attached <= 1'b0;
      cfg.auto_output_attached     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wrgc_pkg::REG_DOUBLE_PRESS_WINDOW: cfg.double_press_window_ms <= cfg_data;
        wrgc_pkg::REG_LONG_PRESS:          cfg.long_press_ms <= cfg_data;
        wrgc_pkg::REG_AUTO_CTRL_ATTACHED:  cfg.auto_controller_attached <= cfg_data[0];
        wrgc_pkg::REG_AUTO_OUT_ATTACHED:   cfg.auto_output_attached <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/wrgc_core.sv @@
// Gesture logic and gesture state of the winch remote controller.
// Depends on wrgc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wrgc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  wrgc_pkg::sample_t sample,
  input  wrgc_pkg::cfg_t    cfg,
  output wrgc_pkg::result_t result
);

  logic        prev_any_pressed;
  logic [31:0] last_press_time;
  logic [31:0] press_start_time;
  logic        long_press_done;
  logic        remote_driving;

  logic        prev_any_pressed_next;
  logic [31:0] last_press_time_next;
  logic [31:0] press_start_time_next;
  logic        long_press_done_next;
  logic        remote_driving_next;

  logic        any;
  logic        rise;
  logic        fall;
  logic        dbl;
  logic        lng;
  logic        stop1;
  logic        stop2;
  logic [31:0] pst;
  logic        lpd;
  logic [31:0] since_last;
  logic [31:0] since_start;

  always_comb begin
    any  = sample.button_up | sample.button_down | sample.button_third | sample.button_fourth;
    rise = any & ~prev_any_pressed;
    fall = ~any & prev_any_pressed;

    since_last = sample.time_ms - last_press_time;
    dbl = rise && (last_press_time != 32'd0) &&
          (since_last <= {16'd0, cfg.double_press_window_ms});
    stop1 = sample.stop_flag_in | dbl;

    pst = rise ? sample.time_ms : press_start_time;
    lpd = rise ? 1'b0 : long_press_done;
    since_start = sample.time_ms - pst;
    lng = any && stop1 && !lpd && (pst != 32'd0) &&
          (since_start >= {16'd0, cfg.long_press_ms});
    stop2 = stop1 & ~lng;

    prev_any_pressed_next = any;
    last_press_time_next  = rise ? sample.time_ms : last_press_time;
    press_start_time_next = fall ? 32'd0 : pst;
    long_press_done_next  = fall ? 1'b0 : (lpd | lng);

    result.winch_command    = wrgc_pkg::CMD_NONE;
    result.stop_flag_out    = stop2;
    result.stop_flag_write  = dbl | lng;
    result.auto_disable     = 1'b0;
    result.auto_output_zero = 1'b0;
    result.handled          = 1'b0;
    remote_driving_next     = remote_driving;

    if (stop2) begin
      if (remote_driving) begin
        result.winch_command = wrgc_pkg::CMD_STOP;
        remote_driving_next  = 1'b0;
      end
    end else begin
      if ((sample.button_up | sample.button_down) && cfg.auto_controller_attached &&
          sample.auto_enabled_in) begin
        result.auto_disable     = 1'b1;
        result.auto_output_zero = cfg.auto_output_attached;
      end
      priority if (sample.button_up) begin
        result.winch_command = wrgc_pkg::CMD_UP;
        remote_driving_next  = 1'b1;
        result.handled       = 1'b1;
      end else if (sample.button_down) begin
        result.winch_command = wrgc_pkg::CMD_DOWN;
        remote_driving_next  = 1'b1;
        result.handled       = 1'b1;
      end else begin
        if (remote_driving) begin
          result.winch_command = wrgc_pkg::CMD_STOP;
          remote_driving_next  = 1'b0;
          result.handled       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_any_pressed <= 1'b0;
      last_press_time  <= 32'd0;
      press_start_time <= 32'd0;
      long_press_done  <= 1'b0;
      remote_driving   <= 1'b0;
    end else if (en) begin
      prev_any_pressed <= prev_any_pressed_next;
      last_press_time  <= last_press_time_next;
      press_start_time <= press_start_time_next;
      long_press_done  <= long_press_done_next;
      remote_driving   <= remote_driving_next;
    end
  end

  `ASSERT_NEXT(a_drive_sets_flag, en && (result.winch_command == wrgc_pkg::CMD_UP || result.winch_command == wrgc_pkg::CMD_DOWN), remote_driving, "up or down did not mark remote driving")
  `ASSERT_IMPL(a_handled_has_cmd, result.handled, result.winch_command != wrgc_pkg::CMD_NONE, "handled without a command")
  `ASSERT_IMPL(a_stopped_quiet, result.stop_flag_out, !result.handled && !result.auto_disable, "remote acted while stopped")
  `ASSERT_IMPL(a_zero_needs_disable, result.auto_output_zero, result.auto_disable, "auto output zeroed without disable")

endmodule

@@ rtl/winch_remote_gesture_controller.sv @@
// Top level of the winch remote gesture controller: input and result registers.
// Depends on wrgc_pkg, wrgc_cfg and wrgc_core.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: button sample
//   m_axis    out        m_axis_tvalid/tready       tdata: winch result
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item per cycle sustained while m_axis_tready holds; the result passes the input and result registers.
// The gesture logic between the input and result registers is combinational.
// Reset clears handshake state, gesture state and configuration to defaults.
// A stalled result holds the input register; otherwise an item is taken every cycle.
module winch_remote_gesture_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] button_up, [1] button_down, [2] button_third, [3] button_fourth,
  // [35:4] time_ms, [36] stop_flag_in, [37] auto_enabled_in, [39:38] zero
  input  logic [wrgc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] winch_command, [2] stop_flag_out, [3] stop_flag_write,
  // [4] auto_disable, [5] auto_output_zero, [6] handled, [7] zero
  output logic [wrgc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [wrgc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  wrgc_pkg::cfg_t    cfg;
  wrgc_pkg::sample_t in_sample;
  wrgc_pkg::result_t core_result;
  wrgc_pkg::result_t out_result;
  logic              in_valid;
  logic              advance;

  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample.button_up       <= s_axis_tdata[0];
      in_sample.button_down     <= s_axis_tdata[1];
      in_sample.button_third    <= s_axis_tdata[2];
      in_sample.button_fourth   <= s_axis_tdata[3];
      in_sample.time_ms         <= s_axis_tdata[35:4];
      in_sample.stop_flag_in    <= s_axis_tdata[36];
      in_sample.auto_enabled_in <= s_axis_tdata[37];
    end
  end

  wrgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (wrgc_pkg::reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wrgc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (in_valid & advance),
    .sample (in_sample),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {1'b0, out_result.handled, out_result.auto_output_zero,
                         out_result.auto_disable, out_result.stop_flag_write,
                         out_result.stop_flag_out, out_result.winch_command};

endmodule
